[rtl/lbh_pkg.sv]
// ============================================================================
// lbh_pkg
// Shared types, constants and the lookup2 mix row for the byte stream hash.
// ============================================================================
`default_nettype none

package lbh_pkg;

    localparam logic [31:0] Golden    = 32'h9e37_79b9;
    localparam logic [31:0] InitReset = 32'h1c8c_fbff;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);
    localparam int unsigned QCw    = $clog2(QDepth + 1);

    localparam logic [3:0] LastPos = 4'd11;
    localparam logic [3:0] LastRow = 4'd8;

    typedef struct packed {
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
        logic [31:0] count;
        logic        full;
        logic        last;
    } t_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    function automatic t_abc mix_row(input logic [3:0] row, input t_abc s);
        t_abc r;
        r = s;
        unique case (row)
            4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
            4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
            4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
            4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
            4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
            4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
            4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
            4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
            4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/lookup2_byte_stream_hash.sv]
// ============================================================================
// lookup2_byte_stream_hash
// Streaming lookup2 hash over a byte stream, at most one byte per beat.
// ============================================================================
//  Channel   Signals                                   Direction
//  input     i_valid, o_ready, i_data_byte,            in
//            i_has_byte, i_last_item
//  output    o_valid, i_ready, o_hash_value            out
//  config    i_cfg_we, i_cfg_wdata                     in
//
//  The front takes one beat per cycle while the four-entry block queue has room.
//  Each 12-byte block takes one add and nine mix rows in the back.
//  A message end adds the length, mixes nine rows and sets the output register.
//  Reset is synchronous and needs no clearing pass; stalls at the output
//  back up into the queue and then drop o_ready.
// ============================================================================
`default_nettype none

module lookup2_byte_stream_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    logic [31:0]      r_init;
    logic             accept;
    logic             q_push;
    logic             q_pop;
    lbh_pkg::t_desc   q_in;
    lbh_pkg::t_desc   q_head;
    lbh_pkg::t_qstat  q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= lbh_pkg::InitReset;
        end else if (i_cfg_we) begin
            r_init <= i_cfg_wdata;
        end
    end

    assign o_ready = !q_stat.full;
    assign accept  = i_valid && o_ready;

    lbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last_item (i_last_item),
        .i_init      (r_init),
        .o_desc      (q_in),
        .o_push      (q_push)
    );

    lbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    lbh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_qstat      (q_stat),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("Block queue popped while empty.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("Block queue pushed while full.");

    a_tail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_in.full) |-> q_in.last)
        else $error("Partial block queued without a message end.");

    a_push_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> accept)
        else $error("Block queued without an accepted beat.");

endmodule

`default_nettype wire

[rtl/lbh_front.sv]
// ============================================================================
// lbh_front
// Takes message beats, packs bytes into 12-byte blocks and queues blocks.
// ============================================================================
`default_nettype none

module lbh_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_has_byte,
    input  wire logic          i_last_item,
    input  wire logic [31:0]   i_init,
    output lbh_pkg::t_desc     o_desc,
    output logic               o_push
);

    logic [31:0] r_wa, n_wa;
    logic [31:0] r_wb, n_wb;
    logic [23:0] r_wcp, n_wcp;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_count, n_count;
    logic [31:0] r_c_base, n_c_base;
    logic        r_started, n_started;
    logic        r_first, n_first;

    logic        take;
    logic        block_done;
    logic [31:0] cur_wa, cur_wb;
    logic [23:0] cur_wcp;
    logic [31:0] count_new;
    logic [31:0] base_sel;
    logic [31:0] wc_raw;

    always_comb begin
        take       = i_accept && i_has_byte;
        block_done = take && (r_pos == lbh_pkg::LastPos);
        count_new  = r_count + {31'd0, take};
        cur_wa     = r_wa;
        cur_wb     = r_wb;
        cur_wcp    = r_wcp;
        if (take) begin
            priority if (r_pos < 4'd4) begin
                cur_wa[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
            end else if (r_pos < 4'd8) begin
                cur_wb[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
            end else if (r_pos < lbh_pkg::LastPos) begin
                cur_wcp[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
            end else begin
                cur_wcp = r_wcp;
            end
        end
        if (!r_first) begin
            base_sel = 32'd0;
        end else if (r_started) begin
            base_sel = r_c_base;
        end else begin
            base_sel = i_init;
        end
        wc_raw = block_done ? {i_data_byte, r_wcp} : {cur_wcp, 8'h00};

        o_push       = i_accept && (block_done || i_last_item);
        o_desc.wa    = cur_wa;
        o_desc.wb    = cur_wb;
        o_desc.wc    = wc_raw + base_sel;
        o_desc.count = count_new;
        o_desc.full  = block_done;
        o_desc.last  = i_last_item;
    end

    always_comb begin
        n_wa      = r_wa;
        n_wb      = r_wb;
        n_wcp     = r_wcp;
        n_pos     = r_pos;
        n_count   = r_count;
        n_c_base  = r_c_base;
        n_started = r_started;
        n_first   = r_first;
        if (i_accept) begin
            if (i_last_item) begin
                n_wa      = 32'd0;
                n_wb      = 32'd0;
                n_wcp     = 24'd0;
                n_pos     = 4'd0;
                n_count   = 32'd0;
                n_started = 1'b0;
                n_first   = 1'b1;
            end else if (block_done) begin
                n_wa      = 32'd0;
                n_wb      = 32'd0;
                n_wcp     = 24'd0;
                n_pos     = 4'd0;
                n_count   = count_new;
                n_started = 1'b1;
                n_first   = 1'b0;
            end else if (take) begin
                n_wa      = cur_wa;
                n_wb      = cur_wb;
                n_wcp     = cur_wcp;
                n_pos     = r_pos + 4'd1;
                n_count   = count_new;
                n_started = 1'b1;
                if (!r_started) begin
                    n_c_base = i_init;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa      <= 32'd0;
            r_wb      <= 32'd0;
            r_wcp     <= 24'd0;
            r_pos     <= 4'd0;
            r_count   <= 32'd0;
            r_started <= 1'b0;
            r_first   <= 1'b1;
        end else begin
            r_wa      <= n_wa;
            r_wb      <= n_wb;
            r_wcp     <= n_wcp;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_started <= n_started;
            r_first   <= n_first;
        end
        r_c_base <= n_c_base;
    end

endmodule

`default_nettype wire

[rtl/lbh_queue.sv]
// ============================================================================
// lbh_queue
// Small block queue between the packing front and the mixing back.
// ============================================================================
`default_nettype none

module lbh_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lbh_pkg::t_desc i_desc,
    input  wire logic           i_pop,
    output lbh_pkg::t_desc      o_head,
    output lbh_pkg::t_qstat     o_stat
);

    lbh_pkg::t_desc r_mem [lbh_pkg::QDepth];

    logic [lbh_pkg::QAw-1:0] r_wr_ptr, n_wr_ptr;
    logic [lbh_pkg::QAw-1:0] r_rd_ptr, n_rd_ptr;
    logic [lbh_pkg::QCw-1:0] r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr + lbh_pkg::QAw'(i_push);
        n_rd_ptr = r_rd_ptr + lbh_pkg::QAw'(i_pop);
        n_fill   = r_fill + lbh_pkg::QCw'(i_push) - lbh_pkg::QCw'(i_pop);

        o_head       = r_mem[r_rd_ptr];
        o_stat.empty = (r_fill == '0);
        o_stat.full  = (r_fill == lbh_pkg::QCw'(lbh_pkg::QDepth));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

[rtl/lbh_back.sv]
// ============================================================================
// lbh_back
// Adds queued blocks into the hash state, runs the mix and emits the hash.
// ============================================================================
`default_nettype none

module lbh_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lbh_pkg::t_desc  i_head,
    input  wire lbh_pkg::t_qstat i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [31:0]          o_hash_value
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ADD_LEN = 4'b0010,
        S_MIX     = 4'b0100,
        S_EMIT    = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    lbh_pkg::t_abc  r_abc, n_abc;
    lbh_pkg::t_abc  mixed;
    logic [3:0]     r_row, n_row;
    logic           r_last, n_last;
    logic           r_final, n_final;
    logic [31:0]    r_len, n_len;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_out_hash, n_out_hash;

    always_comb begin
        mixed       = lbh_pkg::mix_row(r_row, r_abc);
        n_state     = r_state;
        n_abc       = r_abc;
        n_row       = r_row;
        n_last      = r_last;
        n_final     = r_final;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hash  = r_out_hash;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_abc.a = r_abc.a + i_head.wa;
                    n_abc.b = r_abc.b + i_head.wb;
                    n_abc.c = r_abc.c + i_head.wc;
                    n_last  = i_head.last;
                    n_len   = i_head.count;
                    n_final = 1'b0;
                    n_row   = 4'd0;
                    n_state = i_head.full ? S_MIX : S_ADD_LEN;
                end
            end
            S_ADD_LEN: begin
                n_abc.c = r_abc.c + r_len;
                n_final = 1'b1;
                n_row   = 4'd0;
                n_state = S_MIX;
            end
            S_MIX: begin
                n_abc = mixed;
                n_row = r_row + 4'd1;
                if (r_row == lbh_pkg::LastRow) begin
                    priority if (r_final) begin
                        n_state = S_EMIT;
                    end else if (r_last) begin
                        n_state = S_ADD_LEN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_abc.c;
                    n_abc.a     = lbh_pkg::Golden;
                    n_abc.b     = lbh_pkg::Golden;
                    n_abc.c     = 32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_abc.a     <= lbh_pkg::Golden;
            r_abc.b     <= lbh_pkg::Golden;
            r_abc.c     <= 32'd0;
            r_row       <= 4'd0;
            r_last      <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_abc       <= n_abc;
            r_row       <= n_row;
            r_last      <= n_last;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
        r_len      <= n_len;
        r_out_hash <= n_out_hash;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

`default_nettype wire

[verif/tb_lookup2_byte_stream_hash.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_lookup2_byte_stream_hash
// Self-checking bench for the streaming lookup2 byte hash. A scoreboard
// predicts the hash of each message from the accepted input beats and
// compares every output beat in order. Directed messages come first, then
// randomized messages under three sender and receiver idling patterns, with
// the start value of word c changed between phases.
// ============================================================================

class hash_scoreboard;
    logic [31:0] init_word;
    logic [31:0] wa, wb, wc;
    logic [31:0] tail_c;
    logic [31:0] nbytes;
    logic [3:0]  pos;
    bit          started;
    logic [31:0] hashes_due[$];
    int          errors;

    function new();
        init_word = lbh_pkg::InitReset;
        errors    = 0;
        restart();
    endfunction

    function void restart();
        wa      = 32'h9e37_79b9;
        wb      = 32'h9e37_79b9;
        wc      = init_word;
        tail_c  = '0;
        nbytes  = '0;
        pos     = '0;
        started = 1'b0;
    endfunction

    function void set_init(logic [31:0] v);
        init_word = v;
        if (!started) wc = v;
    endfunction

    function void mix_words();
        logic [31:0] a, b, c;
        a = wa;
        b = wb;
        c = wc;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        wa = a;
        wb = b;
        wc = c;
    endfunction

    function void note_beat(logic [7:0] d, bit has, bit last);
        logic [31:0] dv;
        logic [4:0]  sh;
        dv = {24'd0, d};
        sh = {pos[1:0], 3'b000};
        if (has) begin
            started = 1'b1;
            nbytes  = nbytes + 32'd1;
            if (pos < 4'd4) begin
                wa  = wa + (dv << sh);
                pos = pos + 4'd1;
            end else if (pos < 4'd8) begin
                wb  = wb + (dv << sh);
                pos = pos + 4'd1;
            end else if (pos < 4'd11) begin
                tail_c = tail_c | (dv << sh);
                pos    = pos + 4'd1;
            end else begin
                wc     = wc + tail_c + (dv << 24);
                tail_c = '0;
                mix_words();
                pos = '0;
            end
        end
        if (last) begin
            wc = wc + nbytes;
            wc = wc + (tail_c << 8);
            mix_words();
            hashes_due.push_back(wc);
            restart();
        end
    endfunction

    function void check_hash(logic [31:0] got);
        logic [31:0] want;
        if (hashes_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected hash beat %08h", got);
        end else begin
            want = hashes_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("hash mismatch: expected %08h, got %08h", want, got);
                end
            end
        end
    endfunction

    function int pending();
        return hashes_due.size();
    endfunction
endclass

module tb_lookup2_byte_stream_hash;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte  = 1'b0;
    logic        i_last_item = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [31:0] o_hash_value;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    int tx_idle_pct  = 25;
    int rx_idle_pct  = 57;
    int rx_hold_left = 0;

    hash_scoreboard sb = new();

    lookup2_byte_stream_hash i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_last_item  (i_last_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_beat(i_data_byte, i_has_byte, i_last_item);
            if (o_valid && i_ready) sb.check_hash(o_hash_value);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] d, input bit has, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_has_byte  <= has;
        i_last_item <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_init(input logic [31:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_init(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int n_msgs, input int phase);
        int items, msgs, len, k;
        bit end_on_byte;
        items = 0;
        msgs  = 0;
        while (items < n_items || msgs < n_msgs) begin
            len = ($urandom_range(99) < 10) ? $urandom_range(60, 25) : $urandom_range(24, 0);
            end_on_byte = (len > 0) && ($urandom_range(99) < 70);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(99) < 8) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (k == len - 1));
                items++;
            end
            if (!end_on_byte) begin
                send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
                items++;
            end
            msgs++;
            if (phase == 0 && msgs == 3) rx_hold_left = 400;
            if (phase == 2 && msgs == 5) begin
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero-length message, then a single full block of ones.
        send_beat(8'h00, 1'b0, 1'b1);
        for (k = 0; k < 12; k++) send_beat(8'hff, 1'b1, k == 11);
        // Short tail with an ignored empty beat in the middle.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b1, 1'b1);
        // The start value changes while a message is open.
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'hfe, 1'b1, 1'b0);
        write_init(32'hffff_ffff);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h80, 1'b1, 1'b1);

        write_init($urandom);
        tx_idle_pct = 25;
        rx_idle_pct = 57;
        run_phase(190, 15, 0);

        write_init(32'h0000_0000);
        tx_idle_pct = 57;
        rx_idle_pct = 25;
        run_phase(190, 15, 1);

        write_init(32'hffff_ffff);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(190, 15, 2);

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_lookup2_byte_stream_hash OK");
        end else begin
            $display("tb_lookup2_byte_stream_hash NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_lookup2_byte_stream_hash NOT OK");
        $finish;
    end

endmodule
